// ===== src/smpte_tc_pkg.sv =====
`timescale 1ns / 1ps

package smpte_tc_pkg;

	localparam int unsigned FramesPerHour = 108000;
	localparam int unsigned FramesPerMin  = 1800;
	localparam int unsigned FramesPerSec  = 30;
	localparam int unsigned DropsPerHour  = 108;
	localparam int unsigned DfTenMin      = 17982;
	localparam int unsigned DfMin         = 1798;
	localparam int unsigned DayNdf        = 2592000;
	localparam int unsigned DayDf         = 2589408;
	localparam int unsigned DfTenMinAdd   = 18;
	localparam int unsigned DfMinSteps    = 9;

	localparam logic [0:0] KindTcToCount = 1'b0;
	localparam logic [0:0] KindCountToTc = 1'b1;

	// exact quotient by ceiling reciprocal over the value range used
	localparam int unsigned   Div10Shift   = 12;
	localparam logic [8:0]    Div10Recip   = 9'(((64'd1 << Div10Shift) + 64'd9) / 64'd10);
	localparam int unsigned   TenMinShift  = 40;
	localparam logic [25:0]   TenMinRecip  =
		26'(((64'd1 << TenMinShift) + 64'(DfTenMin) - 64'd1) / 64'(DfTenMin));
	localparam int unsigned   HourShift    = 40;
	localparam logic [23:0]   HourRecip    =
		24'(((64'd1 << HourShift) + 64'(FramesPerHour) - 64'd1) / 64'(FramesPerHour));
	localparam int unsigned   MinShift     = 32;
	localparam logic [21:0]   MinRecip     =
		22'(((64'd1 << MinShift) + 64'(FramesPerMin) - 64'd1) / 64'(FramesPerMin));
	localparam int unsigned   SecShift     = 16;
	localparam logic [11:0]   SecRecip     =
		12'(((64'd1 << SecShift) + 64'(FramesPerSec) - 64'd1) / 64'(FramesPerSec));

	typedef struct packed {
		logic valid;
		logic kind;
		logic oor;
	} ctl_t;

endpackage

// ===== src/smpte_timecode_frame_converter_core.sv =====
`timescale 1ns / 1ps

// 30 fps smpte timecode <-> frame count converter, non-drop or drop-frame
//
// request channel: start with kind, hours_in, minutes_in, seconds_in,
// frames_in and count_in. a request is taken at a rising edge with start high
// and busy low. busy stays low: the pipeline takes one request every cycle.
// kind 0 turns a timecode into count_out, kind 1 turns count_in into a
// timecode; unused result fields read zero. out_of_range flags a count of a
// day or more, with the time fields zeroed.
// result channel: done is high for one cycle with the result fields; the
// receiver has no way to hold results off, so none is needed.
// the request moves through the registered stages to done, throughput one
// request per cycle. the depth of the pipeline comes from the chain
// of constant reciprocal multiplies and remainder steps (ten-minute block,
// hours, minutes, seconds), each multiply followed by a register.
// configuration: cfg_valid / cfg_ready / cfg_data write drop_frame; cfg_ready
// is always high. drop_frame is sampled with each request.
// reset: arst_n clears all stage valid bits and drop_frame; requests in flight
// are dropped and no done follows them.
module smpte_timecode_frame_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [4:0]  hours_in,
	input  logic [5:0]  minutes_in,
	input  logic [5:0]  seconds_in,
	input  logic [4:0]  frames_in,
	input  logic [21:0] count_in,
	output logic        done,
	output logic [21:0] count_out,
	output logic [4:0]  hours_out,
	output logic [5:0]  minutes_out,
	output logic [5:0]  seconds_out,
	output logic [4:0]  frames_out,
	output logic        out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data
);

	logic drop_frame_q;

	smpte_tc_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;

	logic [21:0] tc_sum_s1;
	logic [12:0] tc_drop_s1;
	logic        df_s1, df_s2;
	logic [21:0] n_s1, n_s2;
	logic [47:0] prod_d_s1;

	logic [21:0] tc_s2, tc_s3, tc_s4, tc_s5, tc_s6, tc_s7, tc_s8;
	logic [7:0]  d_s2;
	logic [14:0] r_s2;

	logic [21:0] np_s3, np_s4;
	logic [45:0] prod_h_s4;

	logic [4:0]  h_s5, h_s6, h_s7, h_s8;
	logic [16:0] rem1_s5, rem1_s6;
	logic [38:0] prod_m_s6;

	logic [5:0]  m_s7, m_s8;
	logic [10:0] rem2_s7, rem2_s8;
	logic [22:0] prod_s_s8;

	logic [21:0] count_s9;
	logic [4:0]  hours_s9;
	logic [5:0]  minutes_s9;
	logic [5:0]  seconds_s9;
	logic [4:0]  frames_s9;

	logic        accept;
	logic [14:0] m_div10_prod;
	logic [5:0]  m_div10;
	logic [21:0] tc_sum;
	logic [12:0] tc_drop;
	logic [21:0] day_len;
	logic [7:0]  d_est;
	logic [14:0] r_calc;
	logic [3:0]  q2;
	logic [4:0]  h_est;
	logic [5:0]  m_est;
	logic [5:0]  s_est;
	logic        show_tc;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_frame_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			drop_frame_q <= cfg_data[0];
		end
	end

	// control travels with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.kind  <= kind;
			ctl_s1.oor   <= (kind == smpte_tc_pkg::KindCountToTc) && (count_in >= day_len);
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	// stage 1: timecode products, ten-minute block reciprocal
	always_comb begin
		m_div10_prod = 15'(minutes_in) * 15'(smpte_tc_pkg::Div10Recip);
		m_div10      = 6'(m_div10_prod >> smpte_tc_pkg::Div10Shift);
		tc_sum  = 22'(hours_in) * 22'(smpte_tc_pkg::FramesPerHour)
			+ 22'(minutes_in) * 22'(smpte_tc_pkg::FramesPerMin)
			+ 22'(seconds_in) * 22'(smpte_tc_pkg::FramesPerSec)
			+ 22'(frames_in);
		tc_drop = 13'(hours_in) * 13'(smpte_tc_pkg::DropsPerHour)
			+ {6'd0, minutes_in, 1'b0} - {6'd0, m_div10, 1'b0};
		day_len = drop_frame_q ? 22'(smpte_tc_pkg::DayDf) : 22'(smpte_tc_pkg::DayNdf);
	end

	always_ff @(posedge clk) begin
		tc_sum_s1  <= tc_sum;
		tc_drop_s1 <= tc_drop;
		df_s1      <= drop_frame_q;
		n_s1       <= count_in;
		prod_d_s1  <= 48'(count_in) * 48'(smpte_tc_pkg::TenMinRecip);
	end

	// stage 2: drop subtract, ten-minute quotient and remainder
	always_comb begin
		d_est  = 8'(prod_d_s1 >> smpte_tc_pkg::TenMinShift);
		r_calc = 15'(n_s1 - 22'(d_est) * 22'(smpte_tc_pkg::DfTenMin));
	end

	always_ff @(posedge clk) begin
		tc_s2 <= df_s1 ? (tc_sum_s1 - 22'(tc_drop_s1)) : tc_sum_s1;
		d_s2  <= d_est;
		r_s2  <= r_calc;
		n_s2  <= n_s1;
		df_s2 <= df_s1;
	end

	// stage 3: minute corrections inside the ten-minute block
	always_comb begin
		q2 = '0;
		for (int k = 1; k <= smpte_tc_pkg::DfMinSteps; k++) begin
			if (r_s2 >= 15'(2 + k * smpte_tc_pkg::DfMin)) begin
				q2 = q2 + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		tc_s3 <= tc_s2;
		if (df_s2) begin
			np_s3 <= n_s2 + 22'(d_s2) * 22'(smpte_tc_pkg::DfTenMinAdd) + {17'd0, q2, 1'b0};
		end else begin
			np_s3 <= n_s2;
		end
	end

	// stage 4: hour reciprocal
	always_ff @(posedge clk) begin
		tc_s4     <= tc_s3;
		np_s4     <= np_s3;
		prod_h_s4 <= 46'(np_s3) * 46'(smpte_tc_pkg::HourRecip);
	end

	// stage 5: hours and remainder
	assign h_est = 5'(prod_h_s4 >> smpte_tc_pkg::HourShift);

	always_ff @(posedge clk) begin
		tc_s5   <= tc_s4;
		h_s5    <= h_est;
		rem1_s5 <= 17'(np_s4 - 22'(h_est) * 22'(smpte_tc_pkg::FramesPerHour));
	end

	// stage 6: minute reciprocal
	always_ff @(posedge clk) begin
		tc_s6     <= tc_s5;
		h_s6      <= h_s5;
		rem1_s6   <= rem1_s5;
		prod_m_s6 <= 39'(rem1_s5) * 39'(smpte_tc_pkg::MinRecip);
	end

	// stage 7: minutes and remainder
	assign m_est = 6'(prod_m_s6 >> smpte_tc_pkg::MinShift);

	always_ff @(posedge clk) begin
		tc_s7   <= tc_s6;
		h_s7    <= h_s6;
		m_s7    <= m_est;
		rem2_s7 <= 11'(rem1_s6 - 17'(m_est) * 17'(smpte_tc_pkg::FramesPerMin));
	end

	// stage 8: second reciprocal
	always_ff @(posedge clk) begin
		tc_s8     <= tc_s7;
		h_s8      <= h_s7;
		m_s8      <= m_s7;
		rem2_s8   <= rem2_s7;
		prod_s_s8 <= 23'(rem2_s7) * 23'(smpte_tc_pkg::SecRecip);
	end

	// stage 9: seconds, frames and result masking
	assign s_est   = 6'(prod_s_s8 >> smpte_tc_pkg::SecShift);
	assign show_tc = (ctl_s8.kind == smpte_tc_pkg::KindCountToTc) && !ctl_s8.oor;

	always_ff @(posedge clk) begin
		count_s9   <= (ctl_s8.kind == smpte_tc_pkg::KindTcToCount) ? tc_s8 : '0;
		hours_s9   <= show_tc ? h_s8 : '0;
		minutes_s9 <= show_tc ? m_s8 : '0;
		seconds_s9 <= show_tc ? s_est : '0;
		frames_s9  <= show_tc ?
			5'(rem2_s8 - 11'(s_est) * 11'(smpte_tc_pkg::FramesPerSec)) : '0;
	end

	assign done         = ctl_s9.valid;
	assign out_of_range = ctl_s9.oor;
	assign count_out    = count_s9;
	assign hours_out    = hours_s9;
	assign minutes_out  = minutes_s9;
	assign seconds_out  = seconds_s9;
	assign frames_out   = frames_s9;

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##9 done)
		else $error("request did not complete after nine cycles");

	a_oor_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> hours_out == '0 && minutes_out == '0
			&& seconds_out == '0 && frames_out == '0 && count_out == '0)
		else $error("out of range result carries nonzero fields");

	a_tc_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && ctl_s9.kind == smpte_tc_pkg::KindTcToCount |-> !out_of_range
			&& hours_out == '0 && minutes_out == '0 && seconds_out == '0
			&& frames_out == '0)
		else $error("timecode to count result carries time fields");

	a_tc_range : assert property (@(posedge clk) disable iff (!arst_n)
		done && ctl_s9.kind == smpte_tc_pkg::KindCountToTc && !out_of_range
			|-> hours_out < 5'd24 && minutes_out < 6'd60 && seconds_out < 6'd60
			&& frames_out < 5'd30)
		else $error("timecode field out of range");

	a_count_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && ctl_s9.kind == smpte_tc_pkg::KindCountToTc |-> count_out == '0)
		else $error("count to timecode result carries a count");

endmodule
